>>> rtl/cctb_pkg.sv
`timescale 1ns / 1ps
package cctb_pkg;

	localparam int unsigned MAP_BITS   = 256;
	localparam int unsigned WORD_BITS  = 64;
	localparam int unsigned Q_DEPTH    = 4;
	localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

	// error codes
	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_CURLY  = 2'd1;
	localparam logic [1:0] ERR_UNBAL  = 2'd2;

	// op kinds handed from front to back
	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_SPAN    = 2'd1;
	localparam logic [1:0] OP_SPACE   = 2'd2;
	localparam logic [1:0] OP_WORD    = 2'd3;

	// end-of-string result modes
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ALL    = 2'd1;
	localparam logic [1:0] MODE_DOT    = 2'd2;

	localparam logic [7:0] CODE_NL = 8'd10;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  word_index;
		logic [63:0] member_bits;
		logic [1:0]  error_code;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] lo;
		logic [7:0] hi;
		logic       last;
		logic [1:0] mode;
		logic       invert;
		logic [1:0] err;
	} op_t;

	function automatic logic [MAP_BITS-1:0] space_mask();
		logic [MAP_BITS-1:0] m;
		m = '0;
		m[9]  = 1'b1;
		m[10] = 1'b1;
		m[11] = 1'b1;
		m[12] = 1'b1;
		m[13] = 1'b1;
		m[32] = 1'b1;
		return m;
	endfunction

	function automatic logic [MAP_BITS-1:0] word_mask();
		logic [MAP_BITS-1:0] m;
		m = '0;
		for (int k = 0; k < MAP_BITS; k++) begin
			if ((k >= 48 && k <= 57) || (k >= 65 && k <= 90) || (k >= 97 && k <= 122) || k == 95)
				m[k] = 1'b1;
		end
		return m;
	endfunction

endpackage

>>> rtl/cctb_front.sv
`timescale 1ns / 1ps
module cctb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  cctb_pkg::in_item_t byte_data,
	input  logic              q_full,
	output logic              q_push,
	output cctb_pkg::op_t     q_data
);
	import cctb_pkg::*;

	logic              esc_q, inv_q, rng_q, hex_stop_q;
	logic [7:0]        rng_lo_q, prev_q, hex_val_q, first_q;
	logic signed [7:0] depth_q;
	logic [1:0]        hex_phase_q, bc_q;

	logic              esc_n, inv_n, rng_n, hex_stop_n;
	logic [7:0]        rng_lo_n, prev_n, hex_val_n;
	logic signed [7:0] depth_n;
	logic [1:0]        hex_phase_n;

	logic       accept;
	logic       lit_en;
	logic [7:0] lit_val;
	logic [7:0] c;
	logic       dig_ok;
	logic [3:0] dig;
	logic [7:0] first_eff;
	op_t        op;

	assign c          = byte_data.ch;
	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;
	assign first_eff  = (bc_q == 2'd0) ? c : first_q;

	// hex digit decode
	always_comb begin
		dig_ok = 1'b1;
		dig    = 4'd0;
		if (c >= 8'd48 && c <= 8'd57)
			dig = 4'(c - 8'd48);
		else if (c >= 8'd65 && c <= 8'd70)
			dig = 4'(c - 8'd55);
		else if (c >= 8'd97 && c <= 8'd102)
			dig = 4'(c - 8'd87);
		else
			dig_ok = 1'b0;
	end

	always_comb begin
		esc_n       = esc_q;
		inv_n       = inv_q;
		rng_n       = rng_q;
		rng_lo_n    = rng_lo_q;
		prev_n      = prev_q;
		hex_val_n   = hex_val_q;
		hex_stop_n  = hex_stop_q;
		hex_phase_n = hex_phase_q;
		depth_n     = depth_q;
		lit_en      = 1'b0;
		lit_val     = c;
		op          = '0;
		op.kind     = OP_NONE;

		if (hex_phase_q == 2'd1) begin
			if (!dig_ok) begin
				hex_stop_n = 1'b1;
				hex_val_n  = 8'd0;
			end else begin
				hex_val_n  = {4'd0, dig};
			end
			hex_phase_n = 2'd2;
		end else if (hex_phase_q == 2'd2) begin
			if (!hex_stop_q && dig_ok)
				hex_val_n = {hex_val_q[3:0], dig};
			hex_phase_n = 2'd0;
			hex_stop_n  = 1'b0;
			lit_en      = 1'b1;
			lit_val     = hex_val_n;
		end else if (esc_q) begin
			esc_n = 1'b0;
			case (c)
				"n": begin lit_en = 1'b1; lit_val = 8'd10; end
				"r": begin lit_en = 1'b1; lit_val = 8'd13; end
				"t": begin lit_en = 1'b1; lit_val = 8'd9;  end
				"a": begin lit_en = 1'b1; lit_val = 8'd7;  end
				"b": begin lit_en = 1'b1; lit_val = 8'd8;  end
				"f": begin lit_en = 1'b1; lit_val = 8'd12; end
				"v": begin lit_en = 1'b1; lit_val = 8'd11; end
				"s": op.kind = OP_SPACE;
				"d": begin
					op.kind = OP_SPAN;
					op.lo   = 8'd48;
					op.hi   = 8'd57;
				end
				"w": op.kind = OP_WORD;
				"x": begin
					hex_phase_n = 2'd1;
					hex_val_n   = 8'd0;
					hex_stop_n  = 1'b0;
				end
				default: lit_en = 1'b1;
			endcase
		end else begin
			case (c)
				"[": if (depth_q != 8'sd127) depth_n = depth_q + 8'sd1;
				"]": if (depth_q != -8'sd128) depth_n = depth_q - 8'sd1;
				"\\": esc_n = 1'b1;
				"-": begin
					rng_n    = 1'b1;
					rng_lo_n = prev_q;
				end
				"^": inv_n = 1'b1;
				default: lit_en = 1'b1;
			endcase
		end

		// hex digits still due when the string ends
		if (byte_data.end_of_string && hex_phase_n != 2'd0) begin
			hex_phase_n = 2'd0;
			hex_stop_n  = 1'b0;
			lit_en      = 1'b1;
			lit_val     = hex_val_n;
		end

		// a backward range degenerates to the end char alone
		if (lit_en) begin
			op.kind = OP_SPAN;
			op.hi   = lit_val;
			op.lo   = (rng_n && rng_lo_n <= lit_val) ? rng_lo_n : lit_val;
			rng_n   = 1'b0;
			prev_n  = lit_val;
		end

		op.last   = byte_data.end_of_string;
		op.invert = inv_n;
		op.mode   = MODE_NORMAL;
		op.err    = ERR_OK;
		if (bc_q == 2'd0 && c == "*")
			op.mode = MODE_ALL;
		else if (bc_q == 2'd0 && c == ".")
			op.mode = MODE_DOT;
		else if (first_eff == "{" && c == "}")
			op.err = ERR_CURLY;
		else if (depth_n != 8'sd0)
			op.err = ERR_UNBAL;
	end

	assign q_push = accept && (op.kind != OP_NONE || byte_data.end_of_string);
	assign q_data = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= 1'b0;
			inv_q       <= 1'b0;
			rng_q       <= 1'b0;
			rng_lo_q    <= 8'd0;
			prev_q      <= 8'd0;
			hex_val_q   <= 8'd0;
			hex_stop_q  <= 1'b0;
			hex_phase_q <= 2'd0;
			depth_q     <= 8'sd0;
			bc_q        <= 2'd0;
			first_q     <= 8'd0;
		end else if (accept) begin
			if (byte_data.end_of_string) begin
				esc_q       <= 1'b0;
				inv_q       <= 1'b0;
				rng_q       <= 1'b0;
				rng_lo_q    <= 8'd0;
				prev_q      <= 8'd0;
				hex_val_q   <= 8'd0;
				hex_stop_q  <= 1'b0;
				hex_phase_q <= 2'd0;
				depth_q     <= 8'sd0;
				bc_q        <= 2'd0;
				first_q     <= 8'd0;
			end else begin
				esc_q       <= esc_n;
				inv_q       <= inv_n;
				rng_q       <= rng_n;
				rng_lo_q    <= rng_lo_n;
				prev_q      <= prev_n;
				hex_val_q   <= hex_val_n;
				hex_stop_q  <= hex_stop_n;
				hex_phase_q <= hex_phase_n;
				depth_q     <= depth_n;
				first_q     <= first_eff;
				if (bc_q != 2'd2)
					bc_q <= bc_q + 2'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_string_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_data.end_of_string) |=>
		(bc_q == 2'd0 && !esc_q && hex_phase_q == 2'd0 && depth_q == 8'sd0))
		else $error("per-string state not cleared after end of string");
`endif
endmodule

>>> rtl/cctb_fifo.sv
`timescale 1ns / 1ps
module cctb_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cctb_pkg::op_t push_data,
	output logic          full,
	input  logic          pop,
	output cctb_pkg::op_t head,
	output logic          empty
);
	import cctb_pkg::*;

	op_t                slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + Q_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - Q_CNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("op queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("op queue read while empty");
`endif
endmodule

>>> rtl/cctb_back.sv
`timescale 1ns / 1ps
module cctb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cctb_pkg::op_t      head,
	input  logic               empty,
	output logic               pop,
	output logic               word_valid,
	input  logic               word_stall,
	output cctb_pkg::out_item_t word_data
);
	import cctb_pkg::*;

	localparam logic [MAP_BITS-1:0] SPACE_MASK = space_mask();
	localparam logic [MAP_BITS-1:0] WORD_MASK  = word_mask();

	logic [MAP_BITS-1:0] map_q;
	logic [MAP_BITS-1:0] res_q;
	logic [1:0]          err_q;
	logic [1:0]          word_q;
	logic                busy_q;

	logic [MAP_BITS-1:0] add_mask;
	logic [MAP_BITS-1:0] merged;
	logic [MAP_BITS-1:0] final_map;
	logic                word_take;
	logic                free_for_end;
	logic                load_end;

	// parallel range compare over all codes
	always_comb begin
		add_mask = '0;
		case (head.kind)
			OP_SPAN: begin
				for (int k = 0; k < MAP_BITS; k++)
					add_mask[k] = (8'(k) >= head.lo) && (8'(k) <= head.hi);
			end
			OP_SPACE: add_mask = SPACE_MASK;
			OP_WORD:  add_mask = WORD_MASK;
			default:  add_mask = '0;
		endcase
	end

	assign merged = map_q | add_mask;

	always_comb begin
		case (head.mode)
			MODE_ALL: final_map = '1;
			MODE_DOT: final_map = ~(MAP_BITS'(1) << CODE_NL);
			default:  final_map = head.invert ? ~merged : merged;
		endcase
		if (head.err != ERR_OK)
			final_map = '0;
	end

	assign word_take    = busy_q && !word_stall;
	assign free_for_end = !busy_q || (word_take && word_q == 2'd3);
	assign pop          = !empty && (!head.last || free_for_end);
	assign load_end     = pop && head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q  <= '0;
			busy_q <= 1'b0;
			word_q <= 2'd0;
		end else begin
			if (load_end)
				map_q <= '0;
			else if (pop)
				map_q <= merged;

			if (load_end) begin
				busy_q <= 1'b1;
				word_q <= 2'd0;
			end else if (word_take) begin
				if (word_q == 2'd3)
					busy_q <= 1'b0;
				word_q <= word_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_end) begin
			res_q <= final_map;
			err_q <= head.err;
		end
	end

	assign word_valid             = busy_q;
	assign word_data.word_index   = word_q;
	assign word_data.member_bits  = res_q[word_q*WORD_BITS +: WORD_BITS];
	assign word_data.error_code   = err_q;
	assign word_data.last_word    = (word_q == 2'd3);

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_data.error_code != ERR_OK) |-> (word_data.member_bits == '0))
		else $error("nonzero bitmap word sent with an error code");
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(word_take && word_q != 2'd3) |=> (busy_q && word_q == $past(word_q) + 2'd1))
		else $error("bitmap words out of order");
	a_end_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(load_end && busy_q) |-> (word_take && word_q == 2'd3))
		else $error("new bitmap loaded over words not yet sent");
`endif
endmodule

>>> rtl/char_class_to_bitmap_top.sv
`timescale 1ns / 1ps
// channel  | dir | handshake              | payload
// byte     | in  | byte_valid/byte_stall  | byte_data: ch, end_of_string
// word     | out | word_valid/word_stall  | word_data: word_index, member_bits,
//          |     |                        |            error_code, last_word
//
// one byte transaction per cycle into the front decoder unless the op queue is full;
// a byte's op is written into the queue and is folded into the bitmap at the edge
// that pops it (one 256-way range compare)
// the final byte of a string yields four word transactions, the first valid once that
// byte's op has been popped and the bitmap registered for output; the back end keeps
// folding the next string while those drain, and only waits when a second end of
// string reaches the queue head before the fourth word is taken
// reset (arst_n low) clears all parse state, the bitmap, the queue and the emitter
// byte_stall is the op queue being full; word_stall holds the current word
module char_class_to_bitmap_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  cctb_pkg::in_item_t  byte_data,
	output logic                word_valid,
	input  logic                word_stall,
	output cctb_pkg::out_item_t word_data
);
	import cctb_pkg::*;

	// front to queue
	logic q_push;
	op_t  q_in;
	logic q_full;

	// queue to back
	logic q_pop;
	op_t  q_head;
	logic q_empty;

	// front: escape, hex, range and bracket tracking, classifies each byte into an op
	cctb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	// short op queue decouples parsing from bitmap update and word drain
	cctb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// back: bitmap accumulation and four-word result emission
	cctb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import cctb_pkg::*;

	// structural characters of the class syntax
	localparam bit [7:0] CH_LBRACK = "[";
	localparam bit [7:0] CH_RBRACK = "]";
	localparam bit [7:0] CH_BSLASH = "\\";
	localparam bit [7:0] CH_DASH   = "-";
	localparam bit [7:0] CH_CARET  = "^";
	localparam bit [7:0] CH_STAR   = "*";
	localparam bit [7:0] CH_DOT    = ".";
	localparam bit [7:0] CH_LBRACE = "{";
	localparam bit [7:0] CH_RBRACE = "}";
	localparam bit [7:0] CH_UNDER  = "_";

	// escape letters with a meaning of their own
	localparam bit [7:0] ESC_NL    = "n";
	localparam bit [7:0] ESC_CR    = "r";
	localparam bit [7:0] ESC_TAB   = "t";
	localparam bit [7:0] ESC_BEL   = "a";
	localparam bit [7:0] ESC_BS    = "b";
	localparam bit [7:0] ESC_FF    = "f";
	localparam bit [7:0] ESC_VT    = "v";
	localparam bit [7:0] ESC_SPACE = "s";
	localparam bit [7:0] ESC_DIGIT = "d";
	localparam bit [7:0] ESC_WORD  = "w";
	localparam bit [7:0] ESC_HEX   = "x";

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_CAP   = 40;

	typedef bit [7:0] byte_q_t[$];
	typedef enum {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data = '0;
	logic      word_valid;
	logic      word_stall = 1'b0;
	out_item_t word_data;

	char_class_to_bitmap_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

	// stimulus and scoreboard storage
	in_item_t    byte_pending[$];
	out_item_t   expected_words[$];
	out_item_t   want_word;
	idle_phase_e idle_phase = PH_FREE;
	logic        hold_on = 1'b0;
	int          err_count = 0;
	int          bytes_taken = 0;
	int          strings_done = 0;
	int          words_checked = 0;
	int          quiet_cycles = 0;
	string       esc_letters = "nrtabfvsdwx'\"";
	string       hex_chars = "0123456789abcdefABCDEF";

	// shadow of the parser state, kept per string
	logic [MAP_BITS-1:0] cls_map;
	bit       esc_on;
	bit       inv_on;
	bit       rng_on;
	bit [7:0] rng_lo;
	bit [7:0] prev_lit;
	int       class_depth;
	bit [1:0] hex_ph;
	bit [7:0] hex_val;
	bit       hex_stop;
	bit [1:0] nbytes;
	bit [7:0] lead;

	// 10 ns clock
	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic void clear_class_state();
		cls_map = '0;
		esc_on = 1'b0;
		inv_on = 1'b0;
		rng_on = 1'b0;
		rng_lo = '0;
		prev_lit = '0;
		class_depth = 0;
		hex_ph = '0;
		hex_val = '0;
		hex_stop = 1'b0;
		nbytes = '0;
		lead = '0;
	endfunction

	function automatic void add_span(int lo, int hi);
		for (int k = lo; k <= hi; k++)
			cls_map[k] = 1'b1;
	endfunction

	// a literal also closes any range waiting on it
	function automatic void add_lit(bit [7:0] v);
		cls_map[v] = 1'b1;
		if (rng_on) begin
			add_span(rng_lo, v);
			rng_on = 1'b0;
		end
		prev_lit = v;
	endfunction

	function automatic int hex_nib(bit [7:0] c);
		if (c >= "0" && c <= "9") return c - 8'd48;
		if (c >= "A" && c <= "F") return c - 8'd55;
		if (c >= "a" && c <= "f") return c - 8'd87;
		return -1;
	endfunction

	// fold one accepted byte into the shadow bitmap, queue four words at end of string
	function automatic void fold_class_byte(in_item_t it);
		bit [7:0]            c;
		int                  d;
		logic [MAP_BITS-1:0] words;
		logic [1:0]          err;
		out_item_t           o;
		c = it.ch;
		if (nbytes == 0) lead = c;
		if (nbytes < 2) nbytes++;
		if (hex_ph == 2'd1) begin
			// first digit after \x: a non-hex byte stops the number at zero
			d = hex_nib(c);
			if (d < 0) begin
				hex_stop = 1'b1;
				hex_val = '0;
			end else begin
				hex_val = d[7:0];
			end
			hex_ph = 2'd2;
		end else if (hex_ph == 2'd2) begin
			d = hex_nib(c);
			if (!hex_stop && d >= 0)
				hex_val = {hex_val[3:0], d[3:0]};
			hex_ph = '0;
			hex_stop = 1'b0;
			add_lit(hex_val);
		end else if (esc_on) begin
			esc_on = 1'b0;
			case (c)
				ESC_NL: add_lit(CODE_NL);
				ESC_CR: add_lit(8'd13);
				ESC_TAB: add_lit(8'd9);
				ESC_BEL: add_lit(8'd7);
				ESC_BS: add_lit(8'd8);
				ESC_FF: add_lit(8'd12);
				ESC_VT: add_lit(8'd11);
				ESC_SPACE: begin
					// whitespace class leaves range and previous literal alone
					add_span(9, 13);
					cls_map[32] = 1'b1;
				end
				ESC_DIGIT: add_span(48, 57);
				ESC_WORD: begin
					cls_map[CH_UNDER] = 1'b1;
					add_span(48, 57);
					add_span(65, 90);
					add_span(97, 122);
				end
				ESC_HEX: begin
					hex_ph = 2'd1;
					hex_val = '0;
					hex_stop = 1'b0;
				end
				default: add_lit(c);
			endcase
		end else begin
			case (c)
				CH_LBRACK: if (class_depth < 127) class_depth++;
				CH_RBRACK: if (class_depth > -128) class_depth--;
				CH_BSLASH: esc_on = 1'b1;
				CH_DASH: begin
					rng_on = 1'b1;
					rng_lo = prev_lit;
				end
				CH_CARET: inv_on = 1'b1;
				default: add_lit(c);
			endcase
		end
		if (!it.end_of_string) return;

		// string ends with hex digits still due: take what was gathered
		if (hex_ph != 0) begin
			hex_ph = '0;
			hex_stop = 1'b0;
			add_lit(hex_val);
		end
		words = cls_map;
		err = ERR_OK;
		if (nbytes == 1 && lead == CH_STAR) begin
			words = '1;
		end else if (nbytes == 1 && lead == CH_DOT) begin
			words = '1;
			words[CODE_NL] = 1'b0;
		end else begin
			if (lead == CH_LBRACE && c == CH_RBRACE) err = ERR_CURLY;
			else if (class_depth != 0) err = ERR_UNBAL;
			if (inv_on) words = ~words;
		end
		for (int i = 0; i < 4; i++) begin
			o.word_index = i[1:0];
			o.member_bits = (err != ERR_OK) ? '0 : words[i*WORD_BITS +: WORD_BITS];
			o.error_code = err;
			o.last_word = (i == 3);
			expected_words.push_back(o);
		end
		strings_done++;
		clear_class_state();
	endfunction

	function automatic bit send_pause();
		case (idle_phase)
			PH_SEND_IDLE: return $urandom_range(0, 99) < 70;
			PH_BOTH: return $urandom_range(0, 99) < 17;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit recv_pause();
		case (idle_phase)
			PH_RECV_STALL: return $urandom_range(0, 99) < 70;
			PH_BOTH: return $urandom_range(0, 99) < 17;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit [7:0] rand_lit();
		case ($urandom_range(0, 2))
			0: return 8'($urandom_range("0", "9"));
			1: return 8'($urandom_range("A", "Z"));
			default: return 8'($urandom_range("a", "z"));
		endcase
	endfunction

	// one class string: mostly well-formed tokens, with noise and broken pieces mixed in
	function automatic byte_q_t random_class();
		byte_q_t s;
		bit      open_br;
		case ($urandom_range(0, 19))
			0: begin
				s.push_back(CH_STAR);
				return s;
			end
			1: begin
				s.push_back(CH_DOT);
				return s;
			end
			2: begin
				s.push_back(CH_LBRACE);
				repeat ($urandom_range(0, 3)) s.push_back(rand_lit());
				s.push_back(CH_RBRACE);
				return s;
			end
			default: ;
		endcase
		open_br = ($urandom_range(0, 2) == 0);
		if (open_br) s.push_back(CH_LBRACK);
		if ($urandom_range(0, 3) == 0) s.push_back(CH_CARET);
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 9))
				0, 1: s.push_back(rand_lit());
				2, 3: begin
					s.push_back(rand_lit());
					s.push_back(CH_DASH);
					s.push_back(rand_lit());
				end
				4: begin
					s.push_back(CH_BSLASH);
					s.push_back(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
				end
				5: begin
					s.push_back(CH_BSLASH);
					s.push_back(ESC_HEX);
					repeat (2) begin
						if ($urandom_range(0, 3) == 0)
							s.push_back(rand_lit());
						else
							s.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
					end
				end
				6: s.push_back(8'($urandom_range(0, 255)));
				7: s.push_back($urandom_range(0, 1) ? CH_LBRACK : CH_RBRACK);
				8: begin
					s.push_back(CH_BSLASH);
					s.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					s.push_back(CH_DASH);
					s.push_back(rand_lit());
				end
			endcase
		end
		if (open_br && $urandom_range(0, 5) != 0) s.push_back(CH_RBRACK);
		if ($urandom_range(0, 9) == 0) s.push_back(CH_BSLASH);
		return s;
	endfunction

	task automatic push_bytes(byte_q_t s);
		in_item_t it;
		foreach (s[i]) begin
			it.ch = s[i];
			it.end_of_string = (i == s.size() - 1);
			byte_pending.push_back(it);
		end
	endtask

	task automatic push_text(string t);
		byte_q_t s;
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
		push_bytes(s);
	endtask

	task automatic feed_random(int goal);
		int      pushed;
		byte_q_t s;
		pushed = 0;
		while (pushed < goal) begin
			s = random_class();
			pushed += s.size();
			push_bytes(s);
		end
	endtask

	// sender waits for every byte to go in and every word to come out
	task automatic drain_all();
		do @(posedge clk); while (byte_pending.size() != 0 || byte_valid);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// driver: offer the next pending byte, hold the payload while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall) begin
				// byte transaction accepted: fold it into the prediction
				bytes_taken++;
				fold_class_byte(byte_data);
			end
			if (!byte_valid || !byte_stall) begin
				if (byte_pending.size() != 0 && !send_pause()) begin
					byte_valid <= 1'b1;
					byte_data <= byte_pending.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted word against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			word_stall <= 1'b0;
		end else begin
			if (word_valid && !word_stall) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %0d with nothing expected",
						word_data.word_index));
				end else begin
					want_word = expected_words.pop_front();
					if (word_data.word_index !== want_word.word_index)
						report_mismatch($sformatf("word_index got %0d want %0d",
							word_data.word_index, want_word.word_index));
					if (word_data.member_bits !== want_word.member_bits)
						report_mismatch($sformatf("member_bits[%0d] got %h want %h",
							want_word.word_index, word_data.member_bits,
							want_word.member_bits));
					if (word_data.error_code !== want_word.error_code)
						report_mismatch($sformatf("error_code got %0d want %0d",
							word_data.error_code, want_word.error_code));
					if (word_data.last_word !== want_word.last_word)
						report_mismatch($sformatf("last_word got %b want %b",
							word_data.last_word, want_word.last_word));
				end
			end
			// long hold takes precedence over the random stall pattern
			word_stall <= hold_on || recv_pause();
		end
	end

	// watchdog: too many cycles without any transaction ends the run
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (word_valid && !word_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("char_class_to_bitmap_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		byte_q_t raw_bytes;
		clear_class_state();
		// reset held low from the start, released on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		push_text("*");            // lone star
		push_text(".");            // lone dot
		push_text("{a}");          // curly form
		push_text("[b");           // unbalanced bracket
		push_text("^a-c\\");       // inversion, range, trailing backslash
		push_text("\\xqA");        // non-hex first digit gives zero
		push_text("\\x7");         // string ends inside hex digits
		push_text("z-a");          // backward range keeps only the end
		raw_bytes = '{8'hFF, 8'h00};
		push_bytes(raw_bytes);     // extreme byte codes
		drain_all();

		// random strings across the idling phases, draining fully between them
		for (int p = 0; p < 4; p++) begin
			idle_phase <= idle_phase_e'(p);
			feed_random(48);
			drain_all();
		end

		// receiver holds off while the sender keeps offering, so the input backs up
		idle_phase <= PH_FREE;
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
			feed_random(30);
		join
		drain_all();

		// let any stray word show up before the verdict
		repeat (20) @(posedge clk);
		$display("covered %0d strings in %0d bytes, %0d words checked, %0d errors",
			strings_done, bytes_taken, words_checked, err_count);
		$display("flow: free, sender idle, receiver stall, both, and a %0d-cycle output hold",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("char_class_to_bitmap_top test passed");
		else
			$display("char_class_to_bitmap_top test failed");
		$finish;
	end

endmodule
